[hdl/nrg_pkg.sv]
// Shared types and constants of the nonce replay guard.
`timescale 1ns / 1ps
package nrg_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int CNT_W    = 64;
    localparam int SPAN_W   = 8;
    localparam int LIMIT_W  = 4;
    localparam int FAIL_W   = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Operations
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
    localparam logic [OP_W-1:0] OP_VERDICT = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SESSION = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REPLAY     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd2;

    localparam logic [SPAN_W-1:0]  SPAN_RESET  = 8'd32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
    localparam logic [FAIL_W-1:0]  FAIL_MAX    = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [CNT_W-1:0] nonce_session;
        logic [CNT_W-1:0] nonce_count;
        logic             verdict_ok;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                session_cleared;
        logic                session_active;
    } result_t;

endpackage

[hdl/nonce_replay_guard.sv]
// Top level of the nonce replay guard: sequencer, session state and config.
//
//  Channel   Ports                          Handshake
//  --------  -----------------------------  ----------------------------------
//  request   start, busy, item              taken when start is high, busy low
//  result    done, result                   valid for the single cycle of done
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A start or verdict request ends after the execute step, a failed verdict after
// the fail step; a nonce check with a matching session runs the difference,
// magnitude and window steps, then accept or fail, and an older counter adds a
// one-entry-a-cycle scan of the history RAM through the shared compare unit.
// Reset is asynchronous and needs no clearing pass: valid bits mark history.
// The receiver cannot stall; busy falls at the edge that raises done.
`timescale 1ns / 1ps
module nonce_replay_guard #(
    parameter int HISTORY_DEPTH = nrg_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nrg_pkg::item_t                 item,
    output logic                           done,
    output nrg_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [nrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nrg_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_MAG    = 3'd3;
    localparam logic [2:0] S_WIN    = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_ACCEPT = 3'd6;
    localparam logic [2:0] S_FAIL   = 3'd7;

    logic [2:0]          state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CNT_W-1:0]    d_reg, d_next;
    logic [CNT_W-1:0]    mag_reg, mag_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    logic                active_reg, active_next;
    logic [CNT_W-1:0]    peak_count_reg, peak_count_next;
    logic [AW-1:0]       write_slot_reg, write_slot_next;
    logic [FAIL_W-1:0]   failures_reg, failures_next;
    logic [AW:0]         scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;

    logic [CNT_W-1:0]    sid_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [CNT_W-1:0]    alu_a, alu_b, alu_diff;
    logic                alu_eq;
    logic                hist_clear, hist_we;
    logic [CNT_W-1:0]    hist_rd;
    logic [FAIL_W-1:0]   fail_inc;

    nrg_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .eq   (alu_eq)
    );

    nrg_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (hist_clear),
        .wr_en   (hist_we),
        .wr_addr (write_slot_reg),
        .wr_data (item_reg.nonce_count),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (hist_rd)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign fail_inc = (failures_reg == FAIL_MAX) ? FAIL_MAX : failures_reg + 1'b1;

    // The compare unit's operands follow the sequencer step.
    always_comb
    begin
        case (state_reg)
            S_EXEC:
            begin
                alu_a = item_reg.nonce_session;
                alu_b = sid_reg;
            end
            S_DIFF:
            begin
                alu_a = item_reg.nonce_count;
                alu_b = peak_count_reg;
            end
            S_MAG:
            begin
                alu_a = '0;
                alu_b = d_reg;
            end
            default:
            begin
                alu_a = hist_rd;
                alu_b = item_reg.nonce_count;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        d_next          = d_reg;
        mag_next        = mag_reg;
        status_next     = status_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        active_next     = active_reg;
        peak_count_next = peak_count_reg;
        write_slot_next = write_slot_reg;
        failures_next   = failures_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        hist_clear      = 1'b0;
        hist_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                result_next.status          = ST_OK;
                result_next.session_cleared = 1'b0;
                result_next.session_active  = active_reg;
                case (item_reg.operation)
                    OP_START:
                    begin
                        active_next     = 1'b1;
                        peak_count_next = '0;
                        failures_next   = '0;
                        hist_clear      = 1'b1;
                        result_next.session_active = 1'b1;
                    end
                    OP_VERDICT:
                    begin
                        if (!active_reg)
                        begin
                            result_next.status = ST_NO_SESSION;
                        end
                        else if (item_reg.verdict_ok)
                        begin
                            failures_next = '0;
                        end
                        else
                        begin
                            done_next   = 1'b0;
                            status_next = ST_OK;
                            state_next  = S_FAIL;
                        end
                    end
                    OP_CHECK:
                    begin
                        if (!active_reg)
                        begin
                            result_next.status = ST_NO_SESSION;
                        end
                        else if (!alu_eq)
                        begin
                            done_next   = 1'b0;
                            status_next = ST_MISMATCH;
                            state_next  = S_FAIL;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_DIFF;
                        end
                    end
                    default:
                    begin
                        // Unused operation code: report ok, change nothing.
                    end
                endcase
            end
            S_DIFF:
            begin
                d_next     = alu_diff;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mag_next   = d_reg[CNT_W-1] ? alu_diff : d_reg;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                if (mag_reg > {{(CNT_W-SPAN_W){1'b0}}, span_reg})
                begin
                    status_next = ST_OUTSIDE;
                    state_next  = S_FAIL;
                end
                else if (d_reg[CNT_W-1])
                begin
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_ACCEPT;
                end
            end
            S_SCAN:
            begin
                // Read data comes in the cycle after its address; pend marks it.
                if (pend_reg && alu_eq)
                begin
                    status_next = ST_REPLAY;
                    state_next  = S_FAIL;
                end
                else if (scan_idx_reg == (AW+1)'(HISTORY_DEPTH))
                begin
                    state_next = S_ACCEPT;
                end
                else
                begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_ACCEPT:
            begin
                if (!d_reg[CNT_W-1] && (d_reg != '0))
                begin
                    peak_count_next = item_reg.nonce_count;
                end
                hist_we = 1'b1;
                if (write_slot_reg == AW'(HISTORY_DEPTH - 1))
                begin
                    write_slot_next = '0;
                end
                else
                begin
                    write_slot_next = write_slot_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
                result_next.status          = ST_OK;
                result_next.session_cleared = 1'b0;
                result_next.session_active  = active_reg;
            end
            S_FAIL:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                result_next.status = status_reg;
                if (fail_inc >= limit_reg)
                begin
                    active_next     = 1'b0;
                    peak_count_next = '0;
                    failures_next   = '0;
                    hist_clear      = 1'b1;
                    result_next.session_cleared = 1'b1;
                    result_next.session_active  = 1'b0;
                end
                else
                begin
                    failures_next = fail_inc;
                    result_next.session_cleared = 1'b0;
                    result_next.session_active  = active_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            active_reg     <= 1'b0;
            peak_count_reg <= '0;
            write_slot_reg <= '0;
            failures_reg   <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            sid_reg        <= '0;
            span_reg       <= SPAN_RESET;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            active_reg     <= active_next;
            peak_count_reg <= peak_count_next;
            write_slot_reg <= write_slot_next;
            failures_reg   <= failures_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SESSION_ID: sid_reg   <= cfg_data;
                    CFG_SPAN:       span_reg  <= cfg_data[SPAN_W-1:0];
                    CFG_LIMIT:      limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        d_reg      <= d_next;
        mag_reg    <= mag_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

endmodule

[hdl/nrg_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module nrg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/nrg_history.sv]
// History ring of accepted counters: RAM plus per-entry valid bits.
`timescale 1ns / 1ps
module nrg_history #(
    parameter int HISTORY_DEPTH = nrg_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic                             wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
    input  logic [nrg_pkg::CNT_W-1:0]        wr_data,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output logic [nrg_pkg::CNT_W-1:0]        rd_data
);
    import nrg_pkg::*;

    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic                     rd_valid_reg;
    logic [CNT_W-1:0]         ram_q;

    nrg_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // A cleared entry reads as zero, so the RAM itself never needs a sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

[hdl/nrg_alu.sv]
// Shared 64-bit subtract and equality unit.
`timescale 1ns / 1ps
module nrg_alu (
    input  logic [nrg_pkg::CNT_W-1:0] a,
    input  logic [nrg_pkg::CNT_W-1:0] b,
    output logic [nrg_pkg::CNT_W-1:0] diff,
    output logic                      eq
);
    import nrg_pkg::*;

    assign diff = a - b;
    assign eq   = (a == b);

endmodule
